// ===== rtl/core/avr_pkg.sv =====
// ----------------------------------------------------------------------------
// avr_pkg: shared types, constants and functions for the vector rotator
// Holds the item structs, the CORDIC cell data word, the arctangent table
// and the rounding/saturation helper used at the output.
// ----------------------------------------------------------------------------
`default_nettype none

package avr_pkg;

    // Coordinate format and pipeline depth
    localparam int COORD_W         = 32;
    localparam int ROTATION_STAGES = 16;
    localparam int STAGE_IDX_W     = 5;

    // Sine/cosine factors in Q2.30
    localparam int FRAC_W    = 30;
    localparam int COEF_W    = FRAC_W + 2;
    localparam int GAIN_COMP = 652032874;
    localparam int ONE_Q30   = 1 << FRAC_W;

    // CORDIC angle accumulator in degrees, Q.24
    localparam int ZW     = 33;
    localparam int ZSHIFT = 18;

    // Angle handling in 1/64 degree
    localparam int ANG_W        = 16;
    localparam int RED_W        = 15;
    localparam int REST_W       = 13;
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;

    // Products and their sums
    localparam int PROD_W = COORD_W + COEF_W;
    localparam int SUM_W  = PROD_W + 1;

    typedef enum logic [1:0] {
        ROT_YAW   = 2'd0,
        ROT_PITCH = 2'd1,
        ROT_ROLL  = 2'd2,
        ROT_NONE  = 2'd3
    } t_axis;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
        logic [1:0]                axis;
        logic signed [ANG_W-1:0]   angle;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
    } t_out;

    // Rotation state handed from cell to cell
    typedef struct packed {
        logic signed [COEF_W-1:0] cx;
        logic signed [COEF_W-1:0] cy;
        logic signed [ZW-1:0]     cz;
    } t_cordic;

    // Item data that rides along the cell chain
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [1:0]                axis;
        logic [1:0]                quarter;
        logic                      zero;
    } t_side;

    // atan(2^-i) in degrees, Q.24
    function automatic logic signed [ZW-1:0] atan_q24(input logic [STAGE_IDX_W-1:0] idx);
        logic [30:0] v;
        unique case (idx)
            5'd0:    v = 31'd754974720;
            5'd1:    v = 31'd445687602;
            5'd2:    v = 31'd235489088;
            5'd3:    v = 31'd119537938;
            5'd4:    v = 31'd60000934;
            5'd5:    v = 31'd30029717;
            5'd6:    v = 31'd15018523;
            5'd7:    v = 31'd7509720;
            5'd8:    v = 31'd3754917;
            5'd9:    v = 31'd1877466;
            5'd10:   v = 31'd938734;
            5'd11:   v = 31'd469367;
            5'd12:   v = 31'd234684;
            5'd13:   v = 31'd117342;
            5'd14:   v = 31'd58671;
            5'd15:   v = 31'd29335;
            5'd16:   v = 31'd14668;
            5'd17:   v = 31'd7334;
            5'd18:   v = 31'd3667;
            5'd19:   v = 31'd1833;
            5'd20:   v = 31'd917;
            5'd21:   v = 31'd458;
            5'd22:   v = 31'd229;
            5'd23:   v = 31'd115;
            5'd24:   v = 31'd57;
            5'd25:   v = 31'd29;
            5'd26:   v = 31'd14;
            5'd27:   v = 31'd7;
            5'd28:   v = 31'd4;
            5'd29:   v = 31'd2;
            5'd30:   v = 31'd1;
            default: v = 31'd0;
        endcase
        atan_q24 = ZW'(v);
    endfunction

    // Drop the fraction bits (half already added) and clamp to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_round(
        input logic signed [SUM_W-1:0] acc
    );
        logic signed [SUM_W-1:0]  sh;
        logic [SUM_W-COORD_W:0]   hi;
        sh = acc >>> FRAC_W;
        hi = sh[SUM_W-1:COORD_W-1];
        if (&hi || ~|hi) begin
            sat_round = sh[COORD_W-1:0];
        end else if (sh[SUM_W-1]) begin
            sat_round = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_round = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/axis_vector_rotator.sv =====
// ----------------------------------------------------------------------------
// axis_vector_rotator: rotates a Q16.16 vector about a chosen axis (CORDIC)
// Path: input register, the rotation cells, quadrant-fix register, product and sum registers, then the output register.
// Throughput: one item per cycle while the skid is empty; a stalled output fills the skid and holds the pipeline.
// Reset: synchronous active-low; empties the pipeline, no item is lost after it.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_vector_rotator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire avr_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output avr_pkg::t_out       o_out_data
);

    localparam int NS = avr_pkg::ROTATION_STAGES;

    logic                                   en;

    // Angle reduction
    logic signed [avr_pkg::ANG_W:0]         a0;
    logic signed [avr_pkg::ANG_W:0]         a1;
    logic signed [avr_pkg::ANG_W:0]         a2;
    logic signed [avr_pkg::ANG_W:0]         a3;
    logic [avr_pkg::RED_W-1:0]              n_red;

    // Input stage
    logic                                   r_p0_valid;
    logic signed [avr_pkg::COORD_W-1:0]     r_p0_x;
    logic signed [avr_pkg::COORD_W-1:0]     r_p0_y;
    logic signed [avr_pkg::COORD_W-1:0]     r_p0_z;
    logic [1:0]                             r_p0_axis;
    logic [avr_pkg::RED_W-1:0]              r_p0_red;

    // Quarter split and cell chain
    logic [1:0]                             quarter;
    logic [avr_pkg::RED_W-1:0]              rest_w;
    logic [avr_pkg::REST_W-1:0]             rest;
    logic                                   w_valid [NS+1];
    avr_pkg::t_cordic                       w_data  [NS+1];
    avr_pkg::t_side                         w_side  [NS+1];

    // Quadrant fix and plane select
    avr_pkg::t_cordic                       last;
    avr_pkg::t_side                         lside;
    logic signed [avr_pkg::COEF_W-1:0]      cc;
    logic signed [avr_pkg::COEF_W-1:0]      ss;
    logic signed [avr_pkg::COEF_W-1:0]      n_c;
    logic signed [avr_pkg::COEF_W-1:0]      n_s;
    logic signed [avr_pkg::COORD_W-1:0]     n_u;
    logic signed [avr_pkg::COORD_W-1:0]     n_v;
    logic                                   r_f_valid;
    logic signed [avr_pkg::COEF_W-1:0]      r_f_c;
    logic signed [avr_pkg::COEF_W-1:0]      r_f_s;
    logic signed [avr_pkg::COORD_W-1:0]     r_f_u;
    logic signed [avr_pkg::COORD_W-1:0]     r_f_v;
    avr_pkg::t_side                         r_f_side;

    // Multiply stages
    logic signed [avr_pkg::SUM_W-1:0]       acc_u;
    logic signed [avr_pkg::SUM_W-1:0]       acc_v;
    logic                                   r_m1_valid;
    logic                                   r_m2_valid;
    avr_pkg::t_side                         r_m1_side;
    avr_pkg::t_side                         r_m2_side;

    // Output register and skid
    logic signed [avr_pkg::COORD_W-1:0]     rot_u;
    logic signed [avr_pkg::COORD_W-1:0]     rot_v;
    avr_pkg::t_out                          n_out;
    logic                                   inc_valid;
    logic                                   r_out_valid;
    avr_pkg::t_out                          r_out;
    logic                                   r_skid_valid;
    avr_pkg::t_out                          r_skid;

    // The whole pipeline moves unless the skid holds an item
    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    // Reduce the angle into [0, 360) degrees
    always_comb begin
        a0 = (avr_pkg::ANG_W+1)'(i_in_data.angle);
        a1 = a0[avr_pkg::ANG_W] ? a0 + (avr_pkg::ANG_W+1)'(avr_pkg::FULL_TURN) : a0;
        a2 = a1[avr_pkg::ANG_W] ? a1 + (avr_pkg::ANG_W+1)'(avr_pkg::FULL_TURN) : a1;
        a3 = (a2 >= (avr_pkg::ANG_W+1)'(avr_pkg::FULL_TURN))
           ? a2 - (avr_pkg::ANG_W+1)'(avr_pkg::FULL_TURN) : a2;
        n_red = a3[avr_pkg::RED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (en) begin
            r_p0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0_x    <= i_in_data.in_x;
            r_p0_y    <= i_in_data.in_y;
            r_p0_z    <= i_in_data.in_z;
            r_p0_axis <= i_in_data.axis;
            r_p0_red  <= n_red;
        end
    end

    // Split into whole quarter turns and a remainder below 90 degrees
    always_comb begin
        priority if (r_p0_red >= avr_pkg::RED_W'(3 * avr_pkg::QUARTER_TURN)) begin
            quarter = 2'd3;
            rest_w  = r_p0_red - avr_pkg::RED_W'(3 * avr_pkg::QUARTER_TURN);
        end else if (r_p0_red >= avr_pkg::RED_W'(2 * avr_pkg::QUARTER_TURN)) begin
            quarter = 2'd2;
            rest_w  = r_p0_red - avr_pkg::RED_W'(2 * avr_pkg::QUARTER_TURN);
        end else if (r_p0_red >= avr_pkg::RED_W'(avr_pkg::QUARTER_TURN)) begin
            quarter = 2'd1;
            rest_w  = r_p0_red - avr_pkg::RED_W'(avr_pkg::QUARTER_TURN);
        end else begin
            quarter = 2'd0;
            rest_w  = r_p0_red;
        end
        rest = rest_w[avr_pkg::REST_W-1:0];

        w_valid[0]        = r_p0_valid;
        w_data[0].cx      = avr_pkg::COEF_W'(avr_pkg::GAIN_COMP);
        w_data[0].cy      = '0;
        w_data[0].cz      = avr_pkg::ZW'({rest, {avr_pkg::ZSHIFT{1'b0}}});
        w_side[0].x       = r_p0_x;
        w_side[0].y       = r_p0_y;
        w_side[0].z       = r_p0_z;
        w_side[0].axis    = r_p0_axis;
        w_side[0].quarter = quarter;
        w_side[0].zero    = (rest == '0);
    end

    // Chain of rotation cells
    for (genvar g = 0; g < NS; g++) begin : g_cell
        avr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (avr_pkg::STAGE_IDX_W'(g)),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // Apply the quarter turns exactly and pick the rotation plane
    always_comb begin
        last  = w_data[NS];
        lside = w_side[NS];
        cc    = lside.zero ? avr_pkg::COEF_W'(avr_pkg::ONE_Q30) : last.cx;
        ss    = lside.zero ? '0 : last.cy;
        unique case (lside.quarter)
            2'd1: begin
                n_c = -ss;
                n_s = cc;
            end
            2'd2: begin
                n_c = -cc;
                n_s = -ss;
            end
            2'd3: begin
                n_c = ss;
                n_s = -cc;
            end
            default: begin
                n_c = cc;
                n_s = ss;
            end
        endcase
        unique case (lside.axis)
            avr_pkg::ROT_YAW: begin
                n_u = lside.x;
                n_v = lside.z;
            end
            avr_pkg::ROT_PITCH: begin
                n_u = lside.y;
                n_v = lside.z;
            end
            default: begin
                n_u = lside.x;
                n_v = lside.y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid  <= 1'b0;
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
        end else if (en) begin
            r_f_valid  <= w_valid[NS];
            r_m1_valid <= r_f_valid;
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_c     <= n_c;
            r_f_s     <= n_s;
            r_f_u     <= n_u;
            r_f_v     <= n_v;
            r_f_side  <= lside;
            r_m1_side <= r_f_side;
            r_m2_side <= r_m1_side;
        end
    end

    avr_mix u_mix (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_u     (r_f_u),
        .i_v     (r_f_v),
        .i_c     (r_f_c),
        .i_s     (r_f_s),
        .o_acc_u (acc_u),
        .o_acc_v (acc_v)
    );

    // Round, saturate and put the rotated pair back in place
    always_comb begin
        rot_u = avr_pkg::sat_round(acc_u);
        rot_v = avr_pkg::sat_round(acc_v);
        unique case (r_m2_side.axis)
            avr_pkg::ROT_YAW: begin
                n_out.out_x = rot_u;
                n_out.out_y = r_m2_side.y;
                n_out.out_z = rot_v;
            end
            avr_pkg::ROT_PITCH: begin
                n_out.out_x = r_m2_side.x;
                n_out.out_y = rot_u;
                n_out.out_z = rot_v;
            end
            avr_pkg::ROT_ROLL: begin
                n_out.out_x = rot_u;
                n_out.out_y = rot_v;
                n_out.out_z = r_m2_side.z;
            end
            default: begin
                n_out.out_x = r_m2_side.x;
                n_out.out_y = r_m2_side.y;
                n_out.out_z = r_m2_side.z;
            end
        endcase
        inc_valid = r_m2_valid && en;
    end

    // Hold the result; park an arriving item in the skid while the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= inc_valid;
            end
        end else if (inc_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : n_out;
        end else if (inc_valid) begin
            r_skid <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/avr_cell.sv =====
// ----------------------------------------------------------------------------
// avr_cell: one CORDIC rotation cell
// Turns the running (cx, cy) pair by +-atan(2^-stage) toward a zero angle
// residue and hands the result and the item data to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module avr_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic [avr_pkg::STAGE_IDX_W-1:0]     i_stage,
    input  wire logic                                i_valid,
    input  wire avr_pkg::t_cordic                    i_data,
    input  wire avr_pkg::t_side                      i_side,
    output logic                                     o_valid,
    output avr_pkg::t_cordic                         o_data,
    output avr_pkg::t_side                           o_side
);

    logic signed [avr_pkg::COEF_W-1:0] dx;
    logic signed [avr_pkg::COEF_W-1:0] dy;
    logic signed [avr_pkg::ZW-1:0]     at;
    avr_pkg::t_cordic                  n_data;
    avr_pkg::t_cordic                  r_data;
    avr_pkg::t_side                    r_side;
    logic                              r_valid;

    // Rotate in the direction that shrinks the angle residue
    always_comb begin
        dx = i_data.cy >>> i_stage;
        dy = i_data.cx >>> i_stage;
        at = avr_pkg::atan_q24(i_stage);
        if (!i_data.cz[avr_pkg::ZW-1]) begin
            n_data.cx = i_data.cx - dx;
            n_data.cy = i_data.cy + dy;
            n_data.cz = i_data.cz - at;
        end else begin
            n_data.cx = i_data.cx + dx;
            n_data.cy = i_data.cy - dy;
            n_data.cz = i_data.cz + at;
        end
    end

    // Advance the item one cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/core/avr_mix.sv =====
// ----------------------------------------------------------------------------
// avr_mix: plane rotation multiply and accumulate
// Forms u*c - v*s and u*s + v*c over two stages, with the rounding half
// at the 2^-30 weight already added.
// ----------------------------------------------------------------------------
`default_nettype none

module avr_mix (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [avr_pkg::COORD_W-1:0]  i_u,
    input  wire logic signed [avr_pkg::COORD_W-1:0]  i_v,
    input  wire logic signed [avr_pkg::COEF_W-1:0]   i_c,
    input  wire logic signed [avr_pkg::COEF_W-1:0]   i_s,
    output logic signed [avr_pkg::SUM_W-1:0]         o_acc_u,
    output logic signed [avr_pkg::SUM_W-1:0]         o_acc_v
);

    logic signed [avr_pkg::PROD_W-1:0] r_uc;
    logic signed [avr_pkg::PROD_W-1:0] r_vs;
    logic signed [avr_pkg::PROD_W-1:0] r_us;
    logic signed [avr_pkg::PROD_W-1:0] r_vc;
    logic signed [avr_pkg::SUM_W-1:0]  n_acc_u;
    logic signed [avr_pkg::SUM_W-1:0]  n_acc_v;
    logic signed [avr_pkg::SUM_W-1:0]  r_acc_u;
    logic signed [avr_pkg::SUM_W-1:0]  r_acc_v;
    logic signed [avr_pkg::SUM_W-1:0]  half;

    assign half = avr_pkg::SUM_W'(1) <<< (avr_pkg::FRAC_W - 1);

    // Register the four products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_uc <= i_u * i_c;
            r_vs <= i_v * i_s;
            r_us <= i_u * i_s;
            r_vc <= i_v * i_c;
        end
    end

    // Combine the products and add the rounding half
    always_comb begin
        n_acc_u = avr_pkg::SUM_W'(r_uc) - avr_pkg::SUM_W'(r_vs) + half;
        n_acc_v = avr_pkg::SUM_W'(r_us) + avr_pkg::SUM_W'(r_vc) + half;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc_u <= n_acc_u;
            r_acc_v <= n_acc_v;
        end
    end

    assign o_acc_u = r_acc_u;
    assign o_acc_v = r_acc_v;

endmodule

`default_nettype wire
